// ----- rtl/gdo_pkg.sv -----
// Shared types, constants and calendar functions for the Gregorian date offset core.
`timescale 1ns / 1ps
package gdo_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int YEAR_BITS = 16;
	localparam int MOD_CYCLES = 2;
	localparam int CNT_BITS = $clog2(MOD_CYCLES);
	localparam int MOD_BITS = 9;
	localparam int SUB_W = (OFFSET_BITS > YEAR_BITS) ? OFFSET_BITS + 1 : YEAR_BITS + 1;

	// The year is divided by 16 with a shift, then by 25 with a reciprocal multiply.
	// The reciprocal 5243 / 2^17 is exact for every 12-bit dividend.
	localparam int REC_IN_BITS = YEAR_BITS - 4;
	localparam int REC_BITS = 13;
	localparam int REC_SHIFT = 17;
	localparam int PROD_BITS = REC_IN_BITS + REC_BITS;
	localparam int QUO_BITS = PROD_BITS - REC_SHIFT;
	localparam logic [REC_BITS-1:0] REC_DIV25 = REC_BITS'(5243);

	localparam logic [MOD_BITS-1:0] LEAP_CYCLE = MOD_BITS'(400);
	localparam logic [MOD_BITS-1:0] LEAP_CYCLE_LAST = MOD_BITS'(399);
	localparam logic [MOD_BITS-1:0] CENT_1 = MOD_BITS'(100);
	localparam logic [MOD_BITS-1:0] CENT_2 = MOD_BITS'(200);
	localparam logic [MOD_BITS-1:0] CENT_3 = MOD_BITS'(300);

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] DAY_FIRST = 5'd1;
	localparam logic [4:0] DAY_LAST_DEC = 5'd31;
	localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

	typedef struct packed {
		logic [7:0] month_raw;
		logic [7:0] day_raw;
		logic [YEAR_BITS-1:0] year_in;
		logic signed [OFFSET_BITS-1:0] day_offset;
	} gdo_in_t;

	typedef struct packed {
		logic [3:0] month_out;
		logic [4:0] day_out;
		logic [YEAR_BITS-1:0] year_out;
		logic was_corrected;
		logic year_saturated;
	} gdo_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_CLAMP,
		ST_WALK
	} gdo_state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic clamp;
		logic walk;
		logic [CNT_BITS-1:0] step_idx;
	} gdo_ctrl_t;

	typedef struct packed {
		logic finish;
	} gdo_stat_t;

	// Leap test from the two low year bits and the year modulo 400.
	function automatic logic is_leap(input logic [1:0] y_low, input logic [MOD_BITS-1:0] ymod);
		logic cent;
		cent = (ymod == CENT_1) || (ymod == CENT_2) || (ymod == CENT_3);
		return (y_low == 2'b00) && !cent;
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/gdo_sub.sv -----
// Shared compare and subtract unit used by the remainder pass and the month walk.
`timescale 1ns / 1ps
module gdo_sub
	import gdo_pkg::*;
(
	input  logic [SUB_W-1:0] a,
	input  logic [SUB_W-1:0] b,
	output logic [SUB_W-1:0] diff,
	output logic             borrow
);

	logic [SUB_W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[SUB_W-1:0];
	assign borrow = full[SUB_W];

endmodule

// ----- rtl/gdo_seq.sv -----
// Sequencer: year remainder steps, clamp step, then the month walk.
`timescale 1ns / 1ps
module gdo_seq
	import gdo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  gdo_stat_t stat,
	output gdo_ctrl_t ctrl,
	output logic      busy
);

	gdo_state_t state_q, state_nx;
	logic [CNT_BITS-1:0] cnt_q;
	logic cnt_last;

	assign cnt_last = (cnt_q == CNT_BITS'(MOD_CYCLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_MOD) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_MOD;
			end
			ST_MOD: begin
				if (cnt_last) state_nx = ST_CLAMP;
			end
			ST_CLAMP: state_nx = ST_WALK;
			ST_WALK: begin
				if (stat.finish) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.step_idx = cnt_q;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				ctrl.load = start;
			end
			ST_MOD: ctrl.mod_step = 1'b1;
			ST_CLAMP: ctrl.clamp = 1'b1;
			ST_WALK: ctrl.walk = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

// ----- rtl/gregorian_date_offset_core.sv -----
// Top level of the Gregorian date offset core: datapath registers around the shared unit.
// The month walk crosses at most about 1080 month boundaries for a 16-bit offset.
// A reciprocal multiply and a subtract find the year mod 400; the walk crosses a month a cycle.
// Throughput: one transaction at a time; busy stays high until the result is produced.
// Reset clears the sequencer and the done strobe; datapath registers are not reset.
`timescale 1ns / 1ps
module gregorian_date_offset_core
	import gdo_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  gdo_in_t  request,
	output logic     busy,
	output logic     done,
	output gdo_out_t result
);

	gdo_ctrl_t ctrl;
	gdo_stat_t stat;

	logic [7:0] mraw_q, draw_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [YEAR_BITS-1:0] year_q;
	logic [MOD_BITS-1:0] mod_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [OFFSET_BITS-1:0] r_q;
	logic neg_q, corr_q;
	logic done_q;
	gdo_out_t result_q;

	logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
	logic sub_borrow;

	logic [PROD_BITS-1:0] rec_prod;
	logic [YEAR_BITS-1:0] quo_x400;
	logic [4:0] cur_len, left_p1;
	logic cur_leap;
	logic [3:0] month_cl;
	logic [4:0] len_cl, day_cl;
	logic corr_cl;
	logic [3:0] nm, pm;
	logic [YEAR_BITS-1:0] ny, py;
	logic [MOD_BITS-1:0] nmod, pmod;
	logic [4:0] prev_len;
	logic at_top, at_bottom, finish, sat;
	logic [OFFSET_BITS-1:0] mag;

	gdo_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	gdo_sub u_sub (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	// The first step registers year / 400; the second subtracts 400 times it from the year.
	assign rec_prod = PROD_BITS'(year_q[YEAR_BITS-1:4]) * PROD_BITS'(REC_DIV25);
	assign quo_x400 = YEAR_BITS'(quo_q) * YEAR_BITS'(LEAP_CYCLE);

	assign cur_leap = is_leap(year_q[1:0], mod_q);
	assign cur_len = days_in(month_q, cur_leap);
	assign left_p1 = cur_len - day_q + 5'd1;

	always_comb begin
		if (ctrl.mod_step) begin
			sub_a = SUB_W'(year_q);
			sub_b = SUB_W'(quo_x400);
		end else begin
			sub_a = SUB_W'(r_q);
			sub_b = neg_q ? SUB_W'(day_q) : SUB_W'(left_p1);
		end
	end

	always_comb begin
		corr_cl = 1'b0;
		if (mraw_q == 8'd0) begin
			month_cl = MONTH_JAN;
			corr_cl = 1'b1;
		end else if (mraw_q > 8'(MONTH_DEC)) begin
			month_cl = MONTH_DEC;
			corr_cl = 1'b1;
		end else begin
			month_cl = mraw_q[3:0];
		end
		len_cl = days_in(month_cl, cur_leap);
		if (draw_q == 8'd0) begin
			day_cl = DAY_FIRST;
			corr_cl = 1'b1;
		end else if (draw_q > 8'(len_cl)) begin
			day_cl = len_cl;
			corr_cl = 1'b1;
		end else begin
			day_cl = draw_q[4:0];
		end
	end

	// Neighboring months with the year and its remainder carried or borrowed.
	always_comb begin
		if (month_q == MONTH_DEC) begin
			nm = MONTH_JAN;
			ny = year_q + 1'b1;
			nmod = (mod_q == LEAP_CYCLE_LAST) ? '0 : mod_q + 1'b1;
		end else begin
			nm = month_q + 1'b1;
			ny = year_q;
			nmod = mod_q;
		end
		if (month_q == MONTH_JAN) begin
			pm = MONTH_DEC;
			py = year_q - 1'b1;
			pmod = (mod_q == '0) ? LEAP_CYCLE_LAST : mod_q - 1'b1;
		end else begin
			pm = month_q - 1'b1;
			py = year_q;
			pmod = mod_q;
		end
		prev_len = days_in(pm, is_leap(py[1:0], pmod));
	end

	assign at_top = (month_q == MONTH_DEC) && (year_q == YEAR_MAX);
	assign at_bottom = (month_q == MONTH_JAN) && (year_q == '0);
	assign sat = !sub_borrow && (neg_q ? at_bottom : at_top);
	assign finish = sub_borrow || sat;
	assign stat.finish = ctrl.walk && finish;

	assign mag = request.day_offset[OFFSET_BITS-1] ? OFFSET_BITS'(-request.day_offset)
		: OFFSET_BITS'(request.day_offset);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mraw_q <= request.month_raw;
			draw_q <= request.day_raw;
			year_q <= request.year_in;
			neg_q <= request.day_offset[OFFSET_BITS-1];
			r_q <= mag;
			mod_q <= '0;
		end
		if (ctrl.mod_step) begin
			if (ctrl.step_idx == CNT_BITS'(0)) begin
				quo_q <= rec_prod[PROD_BITS-1:REC_SHIFT];
			end else begin
				mod_q <= sub_diff[MOD_BITS-1:0];
			end
		end
		if (ctrl.clamp) begin
			month_q <= month_cl;
			day_q <= day_cl;
			corr_q <= corr_cl;
		end
		if (ctrl.walk && !finish) begin
			r_q <= sub_diff[OFFSET_BITS-1:0];
			if (neg_q) begin
				month_q <= pm;
				year_q <= py;
				mod_q <= pmod;
				day_q <= prev_len;
			end else begin
				month_q <= nm;
				year_q <= ny;
				mod_q <= nmod;
				day_q <= DAY_FIRST;
			end
		end
		if (stat.finish) begin
			result_q.month_out <= month_q;
			result_q.year_out <= year_q;
			result_q.was_corrected <= corr_q;
			result_q.year_saturated <= sat;
			if (sat) begin
				result_q.day_out <= neg_q ? DAY_FIRST : DAY_LAST_DEC;
			end else if (neg_q) begin
				result_q.day_out <= day_q - r_q[4:0];
			end else begin
				result_q.day_out <= day_q + r_q[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stat.finish;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

// ----- rtl/gdo_checker.sv -----
// Port-level checker for the Gregorian date offset core, bound to the top level.
`timescale 1ns / 1ps
module gdo_port_checker
	import gdo_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input gdo_out_t result
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted transaction");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.month_out >= MONTH_JAN) && (result.month_out <= MONTH_DEC))
		else $error("result month out of range");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.day_out != 5'd0))
		else $error("result day is zero");

endmodule

bind gregorian_date_offset_core gdo_port_checker u_gdo_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ----- tb/gdo_checker.sv -----
// Checker for the date offset core: predicts each date shift and compares the results.
`timescale 1ns / 1ps
module gdo_checker
	import gdo_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  gdo_in_t  request,
	input  logic     done,
	input  gdo_out_t result,
	output int       mismatches,
	output int       waiting
);

	gdo_out_t dates_due[$];

	function automatic bit leap_yr(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
		int unsigned n;
		case (m)
			MONTH_FEB: n = leap_yr(y) ? 29 : 28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 30;
			default: n = 31;
		endcase
		return n;
	endfunction

	// Clamps the raw date, then moves it month by month toward the target day.
	function automatic gdo_out_t shifted_date(input gdo_in_t req);
		int unsigned mon, dy, yr, span, len;
		int off;
		bit corr, sat;
		gdo_out_t r;
		corr = 1'b0;
		sat = 1'b0;
		off = req.day_offset;
		yr = req.year_in;
		if (req.month_raw == 0) begin
			mon = MONTH_JAN;
			corr = 1'b1;
		end else if (req.month_raw > MONTH_DEC) begin
			mon = MONTH_DEC;
			corr = 1'b1;
		end else begin
			mon = req.month_raw;
		end
		len = month_len(mon, yr);
		if (req.day_raw == 0) begin
			dy = 1;
			corr = 1'b1;
		end else if (req.day_raw > len) begin
			dy = len;
			corr = 1'b1;
		end else begin
			dy = req.day_raw;
		end
		if (off > 0) begin
			span = off;
			while (span > 0) begin
				len = month_len(mon, yr);
				if (span <= len - dy) begin
					dy += span;
					span = 0;
				end else if (mon == MONTH_DEC && yr == YEAR_MAX) begin
					dy = DAY_LAST_DEC;
					sat = 1'b1;
					span = 0;
				end else begin
					span -= len - dy + 1;
					dy = 1;
					if (mon == MONTH_DEC) begin
						mon = MONTH_JAN;
						yr++;
					end else begin
						mon++;
					end
				end
			end
		end else if (off < 0) begin
			span = -off;
			while (span > 0) begin
				if (span < dy) begin
					dy -= span;
					span = 0;
				end else if (mon == MONTH_JAN && yr == 0) begin
					dy = DAY_FIRST;
					sat = 1'b1;
					span = 0;
				end else begin
					span -= dy;
					if (mon == MONTH_JAN) begin
						mon = MONTH_DEC;
						yr--;
					end else begin
						mon--;
					end
					dy = month_len(mon, yr);
				end
			end
		end
		r.month_out = mon[3:0];
		r.day_out = dy[4:0];
		r.year_out = yr[15:0];
		r.was_corrected = corr;
		r.year_saturated = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int bad;
		gdo_out_t exp_date;
		bad = 0;
		if (!arst_n) begin
			dates_due.delete();
			mismatches <= 0;
			waiting <= 0;
		end else begin
			// The older transaction completes before a new one is queued.
			if (done) begin
				if (dates_due.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $time, result);
					bad++;
				end else begin
					exp_date = dates_due.pop_front();
					if (result.month_out !== exp_date.month_out) begin
						$display("%0t: month_out expected %0d actual %0d", $time,
							exp_date.month_out, result.month_out);
						bad++;
					end
					if (result.day_out !== exp_date.day_out) begin
						$display("%0t: day_out expected %0d actual %0d", $time,
							exp_date.day_out, result.day_out);
						bad++;
					end
					if (result.year_out !== exp_date.year_out) begin
						$display("%0t: year_out expected %0d actual %0d", $time,
							exp_date.year_out, result.year_out);
						bad++;
					end
					if (result.was_corrected !== exp_date.was_corrected) begin
						$display("%0t: was_corrected expected %0b actual %0b", $time,
							exp_date.was_corrected, result.was_corrected);
						bad++;
					end
					if (result.year_saturated !== exp_date.year_saturated) begin
						$display("%0t: year_saturated expected %0b actual %0b", $time,
							exp_date.year_saturated, result.year_saturated);
						bad++;
					end
				end
			end
			if (start && !busy)
				dates_due.push_back(shifted_date(request));
			mismatches <= mismatches + bad;
			waiting <= dates_due.size();
		end
	end

endmodule

// ----- tb/tb_gregorian_date_offset_core.sv -----
// Testbench top for the date offset core: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_gregorian_date_offset_core
	import gdo_pkg::*;
();

	localparam int IDLE_LIMIT = 20000;
	localparam int TAIL_CYCLES = 1200;
	localparam int RANDOM_ITEMS = 100;

	logic     clk;
	logic     arst_n;
	logic     start;
	gdo_in_t  request;
	logic     busy;
	logic     done;
	gdo_out_t result;
	int       mismatches;
	int       waiting;
	int       idle_cycles;
	gdo_in_t  date_jobs[$];

	gregorian_date_offset_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	gdo_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.mismatches(mismatches),
		.waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Ends the run if neither side moves a transaction for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[gregorian_date_offset_core] ERROR");
				$finish;
			end
		end
	end

	function automatic gdo_in_t mk_date(input int m, input int d, input int y, input int o);
		gdo_in_t r;
		r.month_raw = m[7:0];
		r.day_raw = d[7:0];
		r.year_in = y[15:0];
		r.day_offset = o[15:0];
		return r;
	endfunction

	initial begin
		int gap, pick, off, mon, dy, yr;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;

		date_jobs.push_back(mk_date(0, 15, 2023, 0));
		date_jobs.push_back(mk_date(13, 10, 2023, 0));
		date_jobs.push_back(mk_date(255, 255, 65535, 0));
		date_jobs.push_back(mk_date(6, 0, 2023, 5));
		date_jobs.push_back(mk_date(4, 31, 2023, 0));
		date_jobs.push_back(mk_date(2, 29, 1900, 0));
		date_jobs.push_back(mk_date(2, 29, 2000, 1));
		date_jobs.push_back(mk_date(2, 29, 0, 0));
		date_jobs.push_back(mk_date(2, 28, 2024, 1));
		date_jobs.push_back(mk_date(3, 1, 2024, -1));
		date_jobs.push_back(mk_date(12, 31, 2023, 1));
		date_jobs.push_back(mk_date(1, 1, 2024, -1));
		date_jobs.push_back(mk_date(12, 31, 65535, 1));
		date_jobs.push_back(mk_date(12, 1, 65535, 32767));
		date_jobs.push_back(mk_date(1, 1, 0, -1));
		date_jobs.push_back(mk_date(6, 15, 0, -32768));
		date_jobs.push_back(mk_date(1, 1, 2000, 32767));
		date_jobs.push_back(mk_date(12, 31, 2000, -32768));
		date_jobs.push_back(mk_date(7, 4, 1776, 0));
		date_jobs.push_back(mk_date(1, 31, 2100, 29));
		date_jobs.push_back(mk_date(3, 31, 2400, -31));
		date_jobs.push_back(mk_date(12, 30, 65535, 1));
		date_jobs.push_back(mk_date(1, 2, 0, -1));
		date_jobs.push_back(mk_date(9, 30, 1999, -365));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 8)
				mon = $urandom_range(1, 12);
			else if (pick == 8)
				mon = 0;
			else
				mon = $urandom_range(13, 255);
			pick = $urandom_range(0, 9);
			if (pick < 8)
				dy = $urandom_range(1, 31);
			else if (pick == 8)
				dy = 0;
			else
				dy = $urandom_range(32, 255);
			pick = $urandom_range(0, 9);
			if (pick < 6)
				yr = $urandom_range(0, 65535);
			else if (pick == 6)
				yr = $urandom_range(0, 3);
			else if (pick == 7)
				yr = $urandom_range(65530, 65535);
			else
				yr = $urandom_range(0, 655) * 100;
			pick = $urandom_range(0, 9);
			if (pick < 5)
				off = $urandom_range(0, 80);
			else if (pick < 8)
				off = $urandom_range(0, 2000);
			else if (pick == 8)
				off = $urandom_range(0, 32767);
			else
				off = $urandom_range(32700, 32767);
			if ($urandom_range(0, 1))
				off = -off - ($urandom_range(0, 1) & (off == 32767));
			date_jobs.push_back(mk_date(mon, dy, yr, off));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (date_jobs[i]) begin
			pick = $urandom_range(0, 19);
			if (((i / 16) % 3) == 1 || pick < 13)
				gap = 0;
			else if (pick < 19)
				gap = $urandom_range(1, 4);
			else
				gap = $urandom_range(20, 80);
			if (i == date_jobs.size() / 2) begin
				// Let the block drain completely before the next transaction.
				start <= 1'b0;
				do
					@(posedge clk);
				while (waiting != 0);
			end else if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			start <= 1'b1;
			request <= date_jobs[i];
			do
				@(posedge clk);
			while (busy);
		end
		start <= 1'b0;

		do
			@(posedge clk);
		while (waiting != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && waiting == 0)
			$display("[gregorian_date_offset_core] OK");
		else
			$display("[gregorian_date_offset_core] ERROR");
		$finish;
	end

endmodule
